>>> design/seg_pkg.sv
package seg_pkg;

	// Input and output word layouts.
	localparam int unsigned IN_BITS  = 40;
	localparam int unsigned OUT_BITS = 32;

	// Internal widths (radius and z in 1/65536 cm).
	localparam int unsigned RW   = 22;	// radius
	localparam int unsigned DZW  = 27;	// signed plane-to-vertex distance
	localparam int unsigned ADW  = 25;	// magnitude of that distance
	localparam int unsigned SQW  = 52;	// radicand and root work registers
	localparam int unsigned HW   = 26;	// root
	localparam int unsigned NW   = 27;	// root plus distance
	localparam int unsigned KW   = 4;	// integer part of the logarithm
	localparam int unsigned DW   = 30;	// shifted radius (divisor)
	localparam int unsigned QW   = 31;	// Q30 mantissa
	localparam int unsigned LGW  = 20;	// log2 in Q16
	localparam int unsigned SQRT_STEPS = 26;
	localparam int unsigned DIV_STEPS  = 30;
	localparam int unsigned LOG_STEPS  = 16;

	// Azimuth works in units of 1/80 turn, since every angle used is such a multiple.
	localparam int unsigned AZ_STEPS = 80;
	localparam int unsigned AZJ_OFFSET = 240;

	// ln(2) in Q32, rounded.
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// Radii and plane positions, rounded to nearest 1/65536 cm.
	localparam longint RMIN_IN_L  = (64'sd45213 * 64'sd65536 + 64'sd5000) / 64'sd10000;
	localparam longint RMAX_IN_L  = (64'sd17200 * 64'sd65536 + 64'sd500) / 64'sd1000;
	localparam longint RMIN_OUT_L = (64'sd15400 * 64'sd65536 + 64'sd500) / 64'sd1000;
	localparam longint RMAX_OUT_L = (64'sd28000 * 64'sd65536 + 64'sd500) / 64'sd1000;

	localparam logic [RW-1:0] RMIN_IN  = RW'(RMIN_IN_L);
	localparam logic [RW-1:0] RMIN_OUT = RW'(RMIN_OUT_L);
	localparam logic [19:0]   SPAN_IN  = 20'(RMAX_IN_L - RMIN_IN_L);
	localparam logic [19:0]   SPAN_OUT = 20'(RMAX_OUT_L - RMIN_OUT_L);

	localparam longint Z1A = (64'sd320266 * 64'sd65536 + 64'sd500) / 64'sd1000;
	localparam longint Z1B = (64'sd319766 * 64'sd65536 + 64'sd500) / 64'sd1000;
	localparam longint Z2A = (64'sd83666 * 64'sd65536 + 64'sd500) / 64'sd1000;
	localparam longint Z2B = (64'sd83166 * 64'sd65536 + 64'sd500) / 64'sd1000;
	localparam longint Z2C = (64'sd74966 * 64'sd65536 + 64'sd500) / 64'sd1000;
	localparam longint Z2D = (64'sd75466 * 64'sd65536 + 64'sd500) / 64'sd1000;
	localparam longint Z3A = (64'sd63066 * 64'sd65536 + 64'sd500) / 64'sd1000;
	localparam longint Z3B = (64'sd62566 * 64'sd65536 + 64'sd500) / 64'sd1000;

	typedef logic [15:0] az_lut_t [AZ_STEPS];

	// Azimuth in 1/65536 turn for each 1/80 turn step, rounded half up.
	function automatic az_lut_t build_az_lut();
		az_lut_t t;
		for (int i = 0; i < AZ_STEPS; i++) begin
			t[i] = 16'((i * 32768 + 20) / 40);
		end
		return t;
	endfunction

	localparam az_lut_t AZ_LUT = build_az_lut();

	// Ring plane z for detector, ring and hybrid parity.
	function automatic logic signed [DZW-1:0] plane_z(input logic [1:0] det,
			input logic outer, input logic par);
		logic signed [DZW-1:0] z;
		z = '0;
		unique case (det)
			2'd1: z = par ? DZW'(Z1B) : DZW'(Z1A);
			2'd2: begin
				if (outer) z = par ? DZW'(Z2D) : DZW'(Z2C);
				else       z = par ? DZW'(Z2B) : DZW'(Z2A);
			end
			2'd3: begin
				if (outer) z = par ? -DZW'(Z2D) : -DZW'(Z2C);
				else       z = par ? -DZW'(Z3B) : -DZW'(Z3A);
			end
			default: z = '0;
		endcase
		return z;
	endfunction

	// Base angle in 1/80 turn for detector and ring.
	function automatic logic [6:0] base_step(input logic [1:0] det, input logic outer);
		logic [6:0] b;
		b = '0;
		unique case (det)
			2'd1: b = 7'd22;
			2'd2: b = outer ? 7'd1 : 7'd2;
			2'd3: b = outer ? 7'd39 : 7'd38;
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

>>> design/strip_eta_phi_geometry_top.sv
// Strip hit geometry: azimuth and pseudorapidity of one silicon strip hit.
// Input words arrive on the s_axis channel, one result word leaves on the
// m_axis channel for every input word, in the same order.
// The pipeline is 79 register stages deep: one hit enters per cycle while the
// receiver does not stall. The depth is set by the bit-serial chains: a
// 26-step square root, a 30-step mantissa division and 16 squaring steps of
// the base-2 logarithm, one step a stage. Throughput is one word per cycle
// while the receiver does not stall.
// When the receiver holds m_axis_tready low while a result waits, the whole
// pipeline freezes and s_axis_tready falls in the same cycle; nothing is lost
// or repeated, and flow resumes when the result is taken.
// Reset (arst_n low) clears all valid bits; the pipeline is empty after
// reset and accepts a word in the first cycle afterwards.
module strip_eta_phi_geometry_top
	import seg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// detector[1:0], ring_outer[2], sector[8:3], strip[17:9], vertex_z[33:18]
	input  logic [IN_BITS-1:0]  s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// azimuth[15:0], pseudorapidity[31:16]
	output logic [OUT_BITS-1:0] m_axis_tdata
);

	logic en;

	// Input fields.
	logic [1:0]        detector;
	logic              ring_outer;
	logic [5:0]        sector;
	logic [8:0]        strip;
	logic signed [15:0] vertex_z;

	assign detector   = s_axis_tdata[1:0];
	assign ring_outer = s_axis_tdata[2];
	assign sector     = s_axis_tdata[8:3];
	assign strip      = s_axis_tdata[17:9];
	assign vertex_z   = s_axis_tdata[33:18];

	// The pipeline moves whenever the output register is free or being read.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: radius, plane distance and azimuth.
	logic [8:0]            az_prod;
	logic [9:0]            az_j0, az_j1, az_j2, az_j3;
	logic [28:0]           r_prod;
	logic [RW-1:0]         r_c;
	logic signed [DZW-1:0] dz_c;
	logic [DZW-1:0]        adz_c;

	always_comb begin
		az_prod = ring_outer ? {2'b0, sector, 1'b0} : {1'b0, sector, 2'b0};
		if (detector == 2'd3) begin
			az_j0 = 10'(base_step(detector, ring_outer)) + 10'(AZJ_OFFSET) - 10'(az_prod);
		end else begin
			az_j0 = 10'(base_step(detector, ring_outer)) + 10'(AZJ_OFFSET) + 10'(az_prod);
		end
		az_j1 = (az_j0 >= 10'd320) ? az_j0 - 10'd320 : az_j0;
		az_j2 = (az_j1 >= 10'd160) ? az_j1 - 10'd160 : az_j1;
		az_j3 = (az_j2 >= 10'd80) ? az_j2 - 10'd80 : az_j2;

		if (ring_outer) begin
			r_prod = 29'(strip) * 29'(SPAN_OUT);
			r_c = RMIN_OUT + RW'(r_prod >> 8);
		end else begin
			r_prod = 29'(strip) * 29'(SPAN_IN);
			r_c = RMIN_IN + RW'(r_prod >> 9);
		end
		dz_c = plane_z(detector, ring_outer, sector[1])
			- {{3{vertex_z[15]}}, vertex_z, 8'b0};
		adz_c = dz_c[DZW-1] ? DZW'(-dz_c) : DZW'(dz_c);
	end

	logic            v_s1, v_s2, v_s3;
	logic [15:0]     az_s1, az_s2, az_s3;
	logic            neg_s1, neg_s2, neg_s3;
	logic [RW-1:0]   r_s1, r_s2, r_s3;
	logic [ADW-1:0]  adz_s1, adz_s2, adz_s3;
	logic [43:0]     rr_s2;
	logic [49:0]     zz_s2;
	logic [50:0]     sum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			az_s1  <= AZ_LUT[az_j3[6:0]];
			neg_s1 <= dz_c[DZW-1];
			r_s1   <= r_c;
			adz_s1 <= adz_c[ADW-1:0];

			// Stage 2: squares.
			az_s2  <= az_s1;
			neg_s2 <= neg_s1;
			r_s2   <= r_s1;
			adz_s2 <= adz_s1;
			rr_s2  <= 44'(r_s1) * 44'(r_s1);
			zz_s2  <= 50'(adz_s1) * 50'(adz_s1);

			// Stage 3: radicand.
			az_s3  <= az_s2;
			neg_s3 <= neg_s2;
			r_s3   <= r_s2;
			adz_s3 <= adz_s2;
			sum_s3 <= 51'(rr_s2) + 51'(zz_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Square root, one result bit per stage.
	logic           sq_v   [SQRT_STEPS+1];
	logic [15:0]    sq_az  [SQRT_STEPS+1];
	logic           sq_neg [SQRT_STEPS+1];
	logic [RW-1:0]  sq_r   [SQRT_STEPS+1];
	logic [ADW-1:0] sq_adz [SQRT_STEPS+1];
	logic [SQW-1:0] sq_rem [SQRT_STEPS+1];
	logic [SQW-1:0] sq_res [SQRT_STEPS+1];

	assign sq_v[0]   = v_s3;
	assign sq_az[0]  = az_s3;
	assign sq_neg[0] = neg_s3;
	assign sq_r[0]   = r_s3;
	assign sq_adz[0] = adz_s3;
	assign sq_rem[0] = SQW'(sum_s3);
	assign sq_res[0] = '0;

	for (genvar i = 1; i <= SQRT_STEPS; i++) begin : g_sqrt
		localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQRT_STEPS - i));
		logic [SQW-1:0] trial;
		assign trial = sq_res[i-1] + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				sq_az[i]  <= sq_az[i-1];
				sq_neg[i] <= sq_neg[i-1];
				sq_r[i]   <= sq_r[i-1];
				sq_adz[i] <= sq_adz[i-1];
				if (sq_rem[i-1] >= trial) begin
					sq_rem[i] <= sq_rem[i-1] - trial;
					sq_res[i] <= (sq_res[i-1] >> 1) + BIT;
				end else begin
					sq_rem[i] <= sq_rem[i-1];
					sq_res[i] <= sq_res[i-1] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i] <= 1'b0;
			end else if (en) begin
				sq_v[i] <= sq_v[i-1];
			end
		end
	end

	// Integer part of log2((h + |dz|) / r).
	logic [NW-1:0] num_c;
	logic [KW-1:0] k_c;

	always_comb begin
		num_c = NW'(sq_res[SQRT_STEPS][HW-1:0]) + NW'(sq_adz[SQRT_STEPS]);
		k_c = '0;
		for (int i = 0; i < 9; i++) begin
			if ((31'(sq_r[SQRT_STEPS]) << (i + 1)) <= 31'(num_c)) begin
				k_c = k_c + KW'(1);
			end
		end
	end

	logic          kv_q;
	logic [15:0]   az_k_q;
	logic          neg_k_q;
	logic [RW-1:0] r_k_q;
	logic [NW-1:0] num_k_q;
	logic [KW-1:0] k_k_q;

	always_ff @(posedge clk) begin
		if (en) begin
			az_k_q  <= sq_az[SQRT_STEPS];
			neg_k_q <= sq_neg[SQRT_STEPS];
			r_k_q   <= sq_r[SQRT_STEPS];
			num_k_q <= num_c;
			k_k_q   <= k_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kv_q <= 1'b0;
		end else if (en) begin
			kv_q <= sq_v[SQRT_STEPS];
		end
	end

	// Mantissa division: first step sets the leading one, then one bit a stage.
	logic          dv_v   [DIV_STEPS+1];
	logic [15:0]   dv_az  [DIV_STEPS+1];
	logic          dv_neg [DIV_STEPS+1];
	logic [KW-1:0] dv_k   [DIV_STEPS+1];
	logic [DW-1:0] dv_d   [DIV_STEPS+1];
	logic [QW-1:0] dv_rem [DIV_STEPS+1];
	logic [QW-1:0] dv_q   [DIV_STEPS+1];
	logic [DW-1:0] d_c;

	assign d_c = DW'(r_k_q) << k_k_q;

	always_ff @(posedge clk) begin
		if (en) begin
			dv_az[0]  <= az_k_q;
			dv_neg[0] <= neg_k_q;
			dv_k[0]   <= k_k_q;
			dv_d[0]   <= d_c;
			dv_rem[0] <= QW'(num_k_q) - QW'(d_c);
			dv_q[0]   <= QW'(1) << (QW - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= kv_q;
		end
	end

	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
		logic [QW:0] shifted;
		assign shifted = {dv_rem[i-1], 1'b0};

		always_ff @(posedge clk) begin
			if (en) begin
				dv_az[i]  <= dv_az[i-1];
				dv_neg[i] <= dv_neg[i-1];
				dv_k[i]   <= dv_k[i-1];
				dv_d[i]   <= dv_d[i-1];
				if (shifted >= (QW+1)'(dv_d[i-1])) begin
					dv_rem[i] <= QW'(shifted - (QW+1)'(dv_d[i-1]));
					dv_q[i]   <= dv_q[i-1] | (QW'(1) << (DIV_STEPS - i));
				end else begin
					dv_rem[i] <= QW'(shifted);
					dv_q[i]   <= dv_q[i-1];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[i] <= 1'b0;
			end else if (en) begin
				dv_v[i] <= dv_v[i-1];
			end
		end
	end

	// Fraction of log2 by repeated squaring, one bit a stage.
	logic           lg_v   [LOG_STEPS+1];
	logic [15:0]    lg_az  [LOG_STEPS+1];
	logic           lg_neg [LOG_STEPS+1];
	logic [QW-1:0]  lg_m   [LOG_STEPS+1];
	logic [LGW-1:0] lg_val [LOG_STEPS+1];

	assign lg_v[0]   = dv_v[DIV_STEPS];
	assign lg_az[0]  = dv_az[DIV_STEPS];
	assign lg_neg[0] = dv_neg[DIV_STEPS];
	assign lg_m[0]   = dv_q[DIV_STEPS];
	assign lg_val[0] = {dv_k[DIV_STEPS], 16'b0};

	for (genvar i = 1; i <= LOG_STEPS; i++) begin : g_log
		logic [2*QW-1:0] sq;
		logic [QW:0]     t;
		assign sq = (2*QW)'(lg_m[i-1]) * (2*QW)'(lg_m[i-1]);
		assign t  = sq[2*QW-1:QW-1];

		always_ff @(posedge clk) begin
			if (en) begin
				lg_az[i]  <= lg_az[i-1];
				lg_neg[i] <= lg_neg[i-1];
				if (t[QW]) begin
					lg_m[i]   <= t[QW:1];
					lg_val[i] <= lg_val[i-1] | (LGW'(1) << (LOG_STEPS - i));
				end else begin
					lg_m[i]   <= t[QW-1:0];
					lg_val[i] <= lg_val[i-1];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lg_v[i] <= 1'b0;
			end else if (en) begin
				lg_v[i] <= lg_v[i-1];
			end
		end
	end

	// Scale by ln(2), then round and saturate.
	logic        mv_q;
	logic [15:0] az_m_q;
	logic        neg_m_q;
	logic [51:0] prod_m_q;

	always_ff @(posedge clk) begin
		if (en) begin
			az_m_q   <= lg_az[LOG_STEPS];
			neg_m_q  <= lg_neg[LOG_STEPS];
			prod_m_q <= 52'(lg_val[LOG_STEPS]) * 52'(LN2_Q32);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (en) begin
			mv_q <= lg_v[LOG_STEPS];
		end
	end

	logic [52:0] rnd_c;
	logic [16:0] e_c;
	logic [15:0] eta_c;

	always_comb begin
		rnd_c = 53'(prod_m_q) + (53'(1) << 35);
		e_c   = rnd_c[52:36];
		if (neg_m_q) begin
			eta_c = (e_c > 17'd32768) ? 16'h8000 : 16'(-e_c);
		end else begin
			eta_c = (e_c > 17'd32767) ? 16'h7FFF : e_c[15:0];
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {eta_c, az_m_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= mv_q;
		end
	end

endmodule
